FILE: rtl/tbc_pkg.sv
// ----------------------------------------------------------------------------
// tbc_pkg: shared types and constants for the text body byte checker
// Transaction payloads, status codes, register indexes and per-byte state.
// ----------------------------------------------------------------------------
package tbc_pkg;

  // Result status codes
  typedef enum logic [2:0] {
    ST_ACCEPTED    = 3'd0,
    ST_CTRL_START  = 3'd1,
    ST_LINE_LONG   = 3'd2,
    ST_NO_FINAL_NL = 3'd3,
    ST_FINISHED_OK = 3'd4,
    ST_IGNORED     = 3'd5
  } status_e;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_MAX_LINE_LEN = 1'b0,
    CFG_KEYWORD_MASK = 1'b1
  } cfg_idx_e;

  localparam int unsigned CfgDataW  = 64;
  localparam int unsigned ColumnW   = 17;

  localparam logic [7:0]          ByteNewline  = 8'h0A;
  localparam logic [7:0]          ByteCtrlA    = 8'h01;
  localparam logic [7:0]          BytePercent  = 8'h25;
  localparam logic [ColumnW-1:0]  ColumnMax    = '1;
  localparam logic [15:0]         MaxLenReset  = 16'd0;
  localparam logic [63:0]         KwMaskReset  = 64'd113193982;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } tbc_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  out_byte;
    logic        out_valid;
    logic [31:0] line_total;
    logic        keyword_seen;
  } tbc_out_t;

  // Per-stream state carried from one byte to the next (line count kept apart)
  typedef struct packed {
    logic [7:0]         previous_byte;
    logic               keyword_armed;
    logic [ColumnW-1:0] column_count;
    logic               keyword_flag;
    logic               stopped;
  } tbc_state_t;

  localparam tbc_state_t StateReset = '{
    previous_byte: ByteNewline,
    keyword_armed: 1'b0,
    column_count:  '0,
    keyword_flag:  1'b0,
    stopped:       1'b0
  };

endpackage

FILE: rtl/tbc_step.sv
// ----------------------------------------------------------------------------
// tbc_step: per-byte check logic
// Computes the result and the next state for one transaction.
// ----------------------------------------------------------------------------
module tbc_step #(
  parameter int unsigned LINE_COUNT_BITS = 32
) (
  input  tbc_pkg::tbc_in_t            item_i,
  input  tbc_pkg::tbc_state_t         state_i,
  input  logic [LINE_COUNT_BITS-1:0]  lines_i,
  input  logic [15:0]                 max_line_len_i,
  input  logic [63:0]                 kw_mask_i,
  output tbc_pkg::tbc_state_t         state_o,
  output logic [LINE_COUNT_BITS-1:0]  lines_o,
  output tbc_pkg::tbc_out_t           result_o
);

  logic [7:0]                 b;
  logic                       is_letter;
  logic                       kw_flag_new;
  logic [LINE_COUNT_BITS-1:0] lines_new;
  logic [tbc_pkg::ColumnW-1:0] col_new;
  logic                       at_line_start;
  logic                       too_long;
  logic [31:0]                total_cur;
  logic [31:0]                total_new;

  assign b = item_i.data_byte;
  assign is_letter = (b[7:6] == 2'b01) && kw_mask_i[b[5:0]];
  assign kw_flag_new = state_i.keyword_flag
                     | (state_i.keyword_armed && (b == tbc_pkg::BytePercent));
  assign lines_new = ((b == tbc_pkg::ByteNewline) && !(&lines_i))
                   ? lines_i + LINE_COUNT_BITS'(1) : lines_i;
  assign at_line_start = (state_i.previous_byte == tbc_pkg::ByteNewline);

  // Column advances by two per byte after the first, saturating
  always_comb begin
    if (at_line_start) begin
      col_new = '0;
    end else if (state_i.column_count >= (tbc_pkg::ColumnMax - tbc_pkg::ColumnW'(1))) begin
      col_new = tbc_pkg::ColumnMax;
    end else begin
      col_new = state_i.column_count + tbc_pkg::ColumnW'(2);
    end
  end

  assign too_long = (max_line_len_i != '0)
                  && (col_new >= {{(tbc_pkg::ColumnW-16){1'b0}}, max_line_len_i});

  // Line total shown at the port: 32 bits, saturating when the counter is wider
  if (LINE_COUNT_BITS > 32) begin : g_sat
    assign total_cur = (|lines_i[LINE_COUNT_BITS-1:32]) ? '1 : lines_i[31:0];
    assign total_new = (|lines_new[LINE_COUNT_BITS-1:32]) ? '1 : lines_new[31:0];
  end else begin : g_ext
    assign total_cur = 32'(lines_i);
    assign total_new = 32'(lines_new);
  end

  always_comb begin
    state_o  = state_i;
    lines_o  = lines_i;
    result_o = '{status: tbc_pkg::ST_IGNORED, out_byte: '0, out_valid: 1'b0,
                 line_total: total_cur, keyword_seen: state_i.keyword_flag};
    priority if (state_i.stopped) begin
      // everything ignored until reset
    end else if (item_i.end_of_input) begin
      state_o.keyword_armed = 1'b0;
      state_o.stopped       = 1'b1;
      result_o.status = at_line_start ? tbc_pkg::ST_FINISHED_OK
                                      : tbc_pkg::ST_NO_FINAL_NL;
    end else begin
      state_o.keyword_flag  = kw_flag_new;
      state_o.keyword_armed = 1'b0;
      state_o.column_count  = col_new;
      lines_o               = lines_new;
      result_o.line_total   = total_new;
      result_o.keyword_seen = kw_flag_new;
      priority if (at_line_start && (b == tbc_pkg::ByteCtrlA)) begin
        state_o.stopped = 1'b1;
        result_o.status = tbc_pkg::ST_CTRL_START;
      end else if (!at_line_start && too_long) begin
        state_o.stopped = 1'b1;
        result_o.status = tbc_pkg::ST_LINE_LONG;
      end else begin
        state_o.keyword_armed = !kw_flag_new
                              && (state_i.previous_byte == tbc_pkg::BytePercent)
                              && is_letter;
        state_o.previous_byte = b;
        result_o.status    = tbc_pkg::ST_ACCEPTED;
        result_o.out_byte  = b;
        result_o.out_valid = 1'b1;
      end
    end
  end

endmodule

FILE: rtl/text_body_byte_checker.sv
// ----------------------------------------------------------------------------
// text_body_byte_checker: decides whether a file body can be stored as text
// Byte-wide check with line counting, column limit and ID keyword detection.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid_i / in_stall_o / in_data_i): one body byte per
//    transaction, or an end-of-input marker that runs the final-newline check.
//  - Output channel (out_valid_o / out_stall_i / out_data_o): exactly one
//    result per input transaction, in order.
//  - Config port (cfg_we_i / cfg_idx_i / cfg_wdata_i): write only while idle.
//  - Path: each input transaction passes the input register, then the result
//    register. Throughput: one transaction per cycle while the output is not
//    stalled; the single combinational step between the two registers
//    updates all state.
//  - Receiver stall: the result register holds; the input register still
//    drains into it the cycle the result is taken, so in_stall_o only rises
//    when both registers are full and the output is stalled.
//  - Reset: line count cleared, previous byte = newline, no stop, registers
//    return to max_line_len = 0 (no limit) and the default letter mask.
//  - After an error stop or end of input every transaction answers "ignored"
//    until the next reset.
// ----------------------------------------------------------------------------
module text_body_byte_checker #(
  parameter int unsigned LINE_COUNT_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic [0:0]                    cfg_idx_i,
  input  logic [tbc_pkg::CfgDataW-1:0]  cfg_wdata_i,
  // byte input
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  tbc_pkg::tbc_in_t              in_data_i,
  // results
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output tbc_pkg::tbc_out_t             out_data_o
);

  // Config registers
  logic [15:0] max_len_q;
  logic [63:0] kw_mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= tbc_pkg::MaxLenReset;
      kw_mask_q <= tbc_pkg::KwMaskReset;
    end else if (cfg_we_i) begin
      unique case (tbc_pkg::cfg_idx_e'(cfg_idx_i))
        tbc_pkg::CFG_MAX_LINE_LEN: max_len_q <= cfg_wdata_i[15:0];
        tbc_pkg::CFG_KEYWORD_MASK: kw_mask_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Pipeline handshake
  logic in_valid_q;
  logic res_ready;
  logic advance;
  logic in_take;

  assign res_ready  = !out_valid_o || !out_stall_i;
  assign advance    = in_valid_q && res_ready;
  assign in_stall_o = in_valid_q && !res_ready;
  assign in_take    = in_valid_i && !in_stall_o;

  // Input register: payload needs no reset
  tbc_pkg::tbc_in_t in_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_data_i;
    end
  end

  // Stream state, updated as each transaction moves into the result register
  tbc_pkg::tbc_state_t        state_q, state_d;
  logic [LINE_COUNT_BITS-1:0] lines_q, lines_d;
  tbc_pkg::tbc_out_t          result_d;

  tbc_step #(
    .LINE_COUNT_BITS(LINE_COUNT_BITS)
  ) u_step (
    .item_i         (in_q),
    .state_i        (state_q),
    .lines_i        (lines_q),
    .max_line_len_i (max_len_q),
    .kw_mask_i      (kw_mask_q),
    .state_o        (state_d),
    .lines_o        (lines_d),
    .result_o       (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tbc_pkg::StateReset;
      lines_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
      lines_q <= lines_d;
    end
  end

  // Result register
  logic              out_valid_q;
  tbc_pkg::tbc_out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= result_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // Once stopped, only reset restarts the stream
  a_stop_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.stopped |=> state_q.stopped)
    else $error("stop flag cleared without reset");

  // Keyword flag never drops
  a_kw_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.keyword_flag |=> state_q.keyword_flag)
    else $error("keyword flag cleared without reset");

  // Byte is passed through exactly on accepted status
  a_pass_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.out_valid ==
                     (out_data_o.status == tbc_pkg::ST_ACCEPTED)))
    else $error("pass-through flag disagrees with status");

  // Input side only stalls with a full input register
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q))
    else $error("input stalled with room in the pipeline");
`endif

endmodule
